@@ rtl/core/idw_pkg.sv @@
// Shared types, constants and tables of the inverse-distance heat-map renderer.
package idw_pkg;

    // Item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Register map: bit 2 of the byte address selects the register word
    localparam logic REG_EIU = 1'b0;

    // Fixed electrode positions in scene coordinates
    localparam int POS_COUNT = 9;
    localparam int POS_IDX_W = 4;
    localparam int CNT_W     = 4;
    localparam logic signed [7:0] POS_X [POS_COUNT] = '{
        -8'sd20, 8'sd20, -8'sd40, 8'sd40, 8'sd0, 8'sd0, -8'sd56, 8'sd56, 8'sd0
    };
    localparam logic signed [7:0] POS_Y [POS_COUNT] = '{
        -8'sd72, -8'sd72, -8'sd56, -8'sd56, -8'sd24, 8'sd20, 8'sd40, 8'sd40, 8'sd0
    };

    // Head ellipse
    localparam int HEAD_RX2 = 80 * 80;
    localparam int HEAD_RY2 = 88 * 88;
    localparam int ELL_LIM  = HEAD_RX2 * HEAD_RY2;

    // Scene coordinates and squared distance
    localparam int PX_W  = 11;
    localparam int PX2_W = 20;
    localparam int LHS_W = 34;
    localparam int D_W   = 12;
    localparam int D2_W  = 20;

    // Square root of d2 * 2^32, two radicand bits per cell
    localparam int SQ_STEPS = (D2_W + 32) / 2;
    localparam int ROOT_W   = SQ_STEPS;
    localparam int SQREM_W  = ROOT_W + 3;
    localparam int EPS_Q16  = 655;

    // Reciprocal 2^50 / d^2, one quotient bit per cell
    localparam int DD_W     = 2 * ROOT_W;
    localparam int RCREM_W  = DD_W;
    localparam int RC_STEPS = 32;
    localparam int RC_SEED  = 1 << 18;
    localparam int WGT_W    = RC_STEPS;

    // Blend sums and colour division
    localparam int ACT_W   = 18;
    localparam int PROD_W  = WGT_W + 1 + ACT_W;
    localparam int SUMW_W  = WGT_W + CNT_W;
    localparam int SUMA_W  = PROD_W + CNT_W;
    localparam int FULL_W  = SUMW_W + 12;
    localparam int COL_W   = FULL_W + 8;
    localparam int COL_STEPS = 8;

    typedef struct packed {
        logic                valid;
        logic [D2_W-1:0]     rad;
        logic [SQREM_W-1:0]  rem;
        logic [ROOT_W-1:0]   root;
    } t_sq_word;

    typedef struct packed {
        logic                valid;
        logic [DD_W-1:0]     dd;
        logic [RCREM_W-1:0]  rem;
        logic [WGT_W-1:0]    q;
    } t_rc_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_CHECK,
        S_ISSUE,
        S_DRAIN,
        S_PREP,
        S_DIVIDE,
        S_SHADE,
        S_FINISH
    } t_state;

endpackage

@@ rtl/core/idw_sq_cell.sv @@
// One cell of the square-root chain: settles one root bit per cycle.
module idw_sq_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  idw_pkg::t_sq_word i_word,
    output idw_pkg::t_sq_word o_word
);
    import idw_pkg::*;

    t_sq_word             r_word;
    t_sq_word             n_word;
    logic [SQREM_W-1:0]   w_rem_s;
    logic [SQREM_W-1:0]   w_trial;

    always_comb begin
        w_rem_s = {i_word.rem[SQREM_W-3:0], i_word.rad[D2_W-1 -: 2]};
        w_trial = {1'b0, i_word.root, 2'b01};
        n_word.valid = i_word.valid;
        n_word.rad   = {i_word.rad[D2_W-3:0], 2'b00};
        if (w_rem_s >= w_trial) begin
            n_word.rem  = w_rem_s - w_trial;
            n_word.root = {i_word.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_word.rem  = w_rem_s;
            n_word.root = {i_word.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_word.rad  <= n_word.rad;
        r_word.rem  <= n_word.rem;
        r_word.root <= n_word.root;
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
    end

    assign o_word = r_word;

endmodule

@@ rtl/core/idw_rc_cell.sv @@
// One cell of the reciprocal chain: settles one quotient bit per cycle.
module idw_rc_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  idw_pkg::t_rc_word i_word,
    output idw_pkg::t_rc_word o_word
);
    import idw_pkg::*;

    t_rc_word           r_word;
    t_rc_word           n_word;
    logic [RCREM_W:0]   w_rem_s;
    logic [RCREM_W:0]   w_diff;

    always_comb begin
        w_rem_s = {i_word.rem, 1'b0};
        w_diff  = w_rem_s - {1'b0, i_word.dd};
        n_word.valid = i_word.valid;
        n_word.dd    = i_word.dd;
        if (w_rem_s >= {1'b0, i_word.dd}) begin
            n_word.rem = w_diff[RCREM_W-1:0];
            n_word.q   = {i_word.q[WGT_W-2:0], 1'b1};
        end else begin
            n_word.rem = w_rem_s[RCREM_W-1:0];
            n_word.q   = {i_word.q[WGT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_word.dd  <= n_word.dd;
        r_word.rem <= n_word.rem;
        r_word.q   <= n_word.q;
        if (!i_rst_n) begin
            r_word.valid <= 1'b0;
        end else begin
            r_word.valid <= n_word.valid;
        end
    end

    assign o_word = r_word;

endmodule

@@ rtl/core/idw_heatmap_pixel.sv @@
// Top level of the inverse-distance heat-map pixel renderer.
//
// Each input word is either a load (opcode 0: store one electrode activity,
// signed Q5.12) or a pixel (opcode 1: column and row). A load gives no
// result. A pixel outside the head ellipse gives inside_head=0 and zero
// colour, going from the check state straight to finish. A pixel inside it
// walks the first n electrodes (n = electrodes_in_use, capped at the
// electrode count and at nine) one per cycle into a chain of 26 square-root
// cells and then a chain of 32 reciprocal cells; with no electrodes in use
// both chains are skipped. The block takes one pixel at a time. The colour
// step is a shift-subtract divider of eight quotient bits. A finished result
// sits in the output register while the next word is taken. Register
// electrodes_in_use lives at the APB word with bit 2 of the byte address
// clear (byte addresses 0 to 3); writes elsewhere are dropped.
module idw_heatmap_pixel #(
    parameter int ELECTRODES   = 9,
    parameter int IMAGE_WIDTH  = 300,
    parameter int IMAGE_HEIGHT = 300
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_opcode,
    input  logic [3:0]                         i_electrode_index,
    input  logic signed [idw_pkg::ACT_W-1:0]   i_activity_value,
    input  logic [8:0]                         i_pixel_x,
    input  logic [8:0]                         i_pixel_y,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_inside_head,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green
);
    import idw_pkg::*;

    localparam int HALF_W = IMAGE_WIDTH / 2;
    localparam int HALF_H = IMAGE_HEIGHT / 2;
    localparam int MAXE   = (ELECTRODES < POS_COUNT) ? ELECTRODES : POS_COUNT;
    localparam int AW     = (ELECTRODES > 1) ? $clog2(ELECTRODES) : 1;

    // ---------------------------------------------------------------------
    // State and registers
    // ---------------------------------------------------------------------
    t_state                     r_state, n_state;
    logic [3:0]                 r_eiu;
    logic signed [ACT_W-1:0]    r_act [ELECTRODES];

    logic signed [PX_W-1:0]     r_px, r_py;
    logic [PX2_W-1:0]           r_px2, r_py2;
    logic [CNT_W-1:0]           r_n;
    logic [POS_IDX_W-1:0]       r_idx;

    logic [D2_W-1:0]            r_d2;
    logic                       r_d2_v;
    logic [ROOT_W-1:0]          r_d;
    logic                       r_d_v;
    logic [DD_W-1:0]            r_dd;
    logic                       r_dd_v;

    logic [WGT_W-1:0]           r_wq;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_p_v;
    logic [AW-1:0]              r_mul_idx;
    logic [CNT_W-1:0]           r_acc_cnt;
    logic [SUMW_W-1:0]          r_sum_w;
    logic signed [SUMA_W-1:0]   r_sum_a;

    logic [COL_W-1:0]           r_num, r_den;
    logic [7:0]                 r_q;
    logic [2:0]                 r_cnt;
    logic                       r_inside;
    logic [7:0]                 r_red, r_green;

    logic                       r_out_valid;
    logic                       r_o_inside;
    logic [7:0]                 r_o_red, r_o_green;

    // ---------------------------------------------------------------------
    // Control decode
    // ---------------------------------------------------------------------
    logic                       w_in_rdy;
    logic                       w_issue;
    logic                       w_out_load;
    logic                       w_out_free;
    logic                       w_accept;
    logic                       w_cfg_wr;
    logic [CNT_W-1:0]           w_n_eff;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && w_in_rdy;
    assign w_cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_EIU);
    assign w_n_eff    = (r_eiu > CNT_W'(MAXE)) ? CNT_W'(MAXE) : r_eiu;

    // ---------------------------------------------------------------------
    // Datapath combinational terms
    // ---------------------------------------------------------------------
    logic signed [2*PX_W-1:0]   w_px_sq, w_py_sq;
    logic [LHS_W-1:0]           w_lhs;
    logic                       w_in_ellipse;
    logic signed [D_W-1:0]      w_dx, w_dy;
    logic signed [2*D_W-1:0]    w_dx2, w_dy2;
    logic [D2_W-1:0]            w_d2;
    logic signed [PROD_W-1:0]   w_prod;
    logic [FULL_W-1:0]          w_full;
    logic [SUMA_W-1:0]          w_a_u;
    logic                       w_a_nonpos;
    logic                       w_a_sat;
    logic [FULL_W-1:0]          w_a_low;

    assign w_px_sq      = r_px * r_px;
    assign w_py_sq      = r_py * r_py;
    assign w_lhs        = LHS_W'(r_px2) * LHS_W'(HEAD_RY2) + LHS_W'(r_py2) * LHS_W'(HEAD_RX2);
    assign w_in_ellipse = (w_lhs <= LHS_W'(ELL_LIM));

    assign w_dx  = D_W'(r_px) - D_W'(POS_X[r_idx]);
    assign w_dy  = D_W'(r_py) - D_W'(POS_Y[r_idx]);
    assign w_dx2 = w_dx * w_dx;
    assign w_dy2 = w_dy * w_dy;
    assign w_d2  = w_dx2[D2_W-1:0] + w_dy2[D2_W-1:0];

    assign w_full     = {r_sum_w, 12'b0};
    assign w_a_u      = r_sum_a;
    assign w_a_nonpos = r_sum_a[SUMA_W-1] || (r_sum_a == '0);
    assign w_a_sat    = (w_a_u >= SUMA_W'(w_full));
    assign w_a_low    = w_a_u[FULL_W-1:0];

    // ---------------------------------------------------------------------
    // Cell chains: square root, then reciprocal
    // ---------------------------------------------------------------------
    t_sq_word w_sq [SQ_STEPS+1];
    t_rc_word w_rc [RC_STEPS+1];

    always_comb begin
        w_sq[0].valid = r_d2_v;
        w_sq[0].rad   = r_d2;
        w_sq[0].rem   = '0;
        w_sq[0].root  = '0;
        w_rc[0].valid = r_dd_v;
        w_rc[0].dd    = r_dd;
        w_rc[0].rem   = RCREM_W'(RC_SEED);
        w_rc[0].q     = '0;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        idw_sq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_sq[k]),
            .o_word  (w_sq[k+1])
        );
    end

    for (genvar k = 0; k < RC_STEPS; k++) begin : g_rc
        idw_rc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_rc[k]),
            .o_word  (w_rc[k+1])
        );
    end

    assign w_prod = $signed({1'b0, w_rc[RC_STEPS].q}) * r_act[r_mul_idx];

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_opcode == OP_PIXEL)) begin
                    n_state = S_SQUARE;
                end
            end
            S_SQUARE: n_state = S_CHECK;
            S_CHECK: begin
                if (!w_in_ellipse) begin
                    n_state = S_FINISH;
                end else if (r_n == '0) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (r_idx == POS_IDX_W'(r_n - 1'b1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_acc_cnt == r_n) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (w_a_nonpos || w_a_sat) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                if (r_cnt == 3'(COL_STEPS - 1)) begin
                    n_state = S_SHADE;
                end
            end
            S_SHADE: n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer: control outputs
    always_comb begin
        w_in_rdy   = 1'b0;
        w_issue    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE:   w_in_rdy   = 1'b1;
            S_ISSUE:  w_issue    = 1'b1;
            S_FINISH: w_out_load = w_out_free;
            default: begin
                w_in_rdy   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------
    // Configuration register and activity store
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eiu <= 4'd9;
        end else if (w_cfg_wr) begin
            r_eiu <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EIU) ? 32'(r_eiu) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ELECTRODES; e++) begin
                r_act[e] <= '0;
            end
        end else if (w_accept && (i_opcode == OP_LOAD)
                     && ({1'b0, i_electrode_index} < 5'(ELECTRODES))) begin
            r_act[i_electrode_index[AW-1:0]] <= i_activity_value;
        end
    end

    // ---------------------------------------------------------------------
    // Per-pixel datapath
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                // latch scene coordinates and the electrode count
                if (w_accept) begin
                    r_px <= PX_W'({2'b00, i_pixel_x}) - PX_W'(HALF_W);
                    r_py <= PX_W'({2'b00, i_pixel_y}) - PX_W'(HALF_H);
                    r_n  <= w_n_eff;
                end
            end
            S_SQUARE: begin
                r_px2 <= w_px_sq[PX2_W-1:0];
                r_py2 <= w_py_sq[PX2_W-1:0];
            end
            S_CHECK: begin
                r_inside <= w_in_ellipse;
                r_red    <= 8'd0;
                r_green  <= 8'd0;
                r_idx    <= '0;
            end
            S_ISSUE: begin
                r_idx <= r_idx + 1'b1;
            end
            S_PREP: begin
                // settle the clamped cases, else load the colour divider
                if (w_a_nonpos) begin
                    r_red   <= 8'd0;
                    r_green <= 8'd255;
                end else if (w_a_sat) begin
                    r_red   <= 8'd255;
                    r_green <= 8'd0;
                end
                r_num <= (COL_W'(w_a_low) << 8) - COL_W'(w_a_low);
                r_den <= COL_W'(w_full) << (COL_STEPS - 1);
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIVIDE: begin
                if (r_num >= r_den) begin
                    r_num <= r_num - r_den;
                    r_q   <= {r_q[6:0], 1'b1};
                end else begin
                    r_q   <= {r_q[6:0], 1'b0};
                end
                r_den <= r_den >> 1;
                r_cnt <= r_cnt + 1'b1;
            end
            S_SHADE: begin
                // green is 255 minus the ceiling of 255 v
                r_red   <= r_q;
                r_green <= 8'd255 - r_q - 8'(r_num != '0);
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    // Squared distance, root plus offset, and its square
    always_ff @(posedge i_clk) begin
        r_d2 <= w_d2;
        r_d  <= w_sq[SQ_STEPS].root + ROOT_W'(EPS_Q16);
        r_dd <= DD_W'(r_d) * DD_W'(r_d);
        if (!i_rst_n) begin
            r_d2_v <= 1'b0;
            r_d_v  <= 1'b0;
            r_dd_v <= 1'b0;
        end else begin
            r_d2_v <= w_issue;
            r_d_v  <= w_sq[SQ_STEPS].valid;
            r_dd_v <= r_d_v;
        end
    end

    // Weight times activity, then accumulate; arrivals keep issue order
    always_ff @(posedge i_clk) begin
        r_wq   <= w_rc[RC_STEPS].q;
        r_prod <= w_prod;
        if (!i_rst_n) begin
            r_p_v     <= 1'b0;
            r_mul_idx <= '0;
            r_acc_cnt <= '0;
            r_sum_w   <= '0;
            r_sum_a   <= '0;
        end else begin
            r_p_v <= w_rc[RC_STEPS].valid;
            if (r_state == S_CHECK) begin
                r_mul_idx <= '0;
                r_acc_cnt <= '0;
                r_sum_w   <= '0;
                r_sum_a   <= '0;
            end else begin
                if (w_rc[RC_STEPS].valid) begin
                    r_mul_idx <= r_mul_idx + 1'b1;
                end
                if (r_p_v) begin
                    r_sum_w   <= r_sum_w + SUMW_W'(r_wq);
                    r_sum_a   <= r_sum_a + SUMA_W'(r_prod);
                    r_acc_cnt <= r_acc_cnt + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register: hold the word until taken
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_inside <= r_inside;
            r_o_red    <= r_red;
            r_o_green  <= r_green;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready    = w_in_rdy;
    assign o_out_valid   = r_out_valid;
    assign o_inside_head = r_o_inside;
    assign o_red         = r_o_red;
    assign o_green       = r_o_green;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_chain_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rc[RC_STEPS].valid |-> (r_state == S_ISSUE || r_state == S_DRAIN))
        else $error("reciprocal chain delivered outside a pixel walk");

    a_acc_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_acc_cnt <= r_n))
        else $error("more weights accumulated than electrodes issued");

    a_idle_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_p_v && !r_d2_v && !r_dd_v))
        else $error("blend pipeline busy while idle");

    a_colour_sum : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_inside_head) |->
            ((9'(o_red) + 9'(o_green) == 9'd255) || (9'(o_red) + 9'(o_green) == 9'd254)))
        else $error("red and green do not complement");

endmodule
